FILE: rtl/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg: shared types and constants of the unique pattern counter
// Field widths, parameter defaults and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package upc_pkg;

    // Parameter defaults
    localparam int MAX_PATTERNS_DEF      = 256;
    localparam int MAX_PATTERN_BYTES_DEF = 64;
    localparam int COUNT_BITS_DEF        = 24;

    // Port field widths
    localparam int BYTE_BITS  = 8;
    localparam int LEN_BITS   = 7;
    localparam int INDEX_BITS = 8;
    localparam int OCC_BITS   = 24;

    // pattern_len after reset
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd27;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;      // pattern complete: search from slot 0, byte 0
        logic rd;         // read buffer and store at current slot and byte
        logic next_byte;  // advance byte pointer
        logic next_slot;  // advance slot, restart at byte 0
        logic clr_byte;   // byte pointer back to 0
        logic cnt_rd;     // read count of current slot
        logic cnt_wr;     // write saturated count, stage hit result
        logic cp_wr;      // write one byte of the appended entry
        logic drop;       // stage table-full result
        logic out_load;   // move staged result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pat_done;   // accepted byte closes a pattern
        logic slot_end;   // all stored entries searched
        logic tbl_full;   // no free slot left
        logic byte_eq;    // compared bytes are equal
        logic last_byte;  // byte pointer on last byte of the pattern
        logic last_pad;   // byte pointer on last byte of an entry
        logic out_free;   // output register can take a result
    } t_dp_sts;

endpackage

FILE: rtl/upc_dp.sv
// ----------------------------------------------------------------------------
// upc_dp: datapath of the unique pattern counter
// Holds the length register, the pattern buffer, the pattern store, the
// occurrence counts, the walk pointers and the output register.
// ----------------------------------------------------------------------------
module upc_dp
    import upc_pkg::*;
#(
    parameter int MAX_PATTERNS      = MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_acc,
    input  logic [BYTE_BITS-1:0]  i_pixel_byte,
    input  logic                  i_cfg_acc,
    input  logic [LEN_BITS-1:0]   i_pattern_len,
    input  logic                  i_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_valid,
    output logic [INDEX_BITS-1:0] o_pattern_index,
    output logic                  o_is_new,
    output logic [OCC_BITS-1:0]   o_occurrences,
    output logic                  o_table_full
);

    localparam int SLOT_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
    localparam int BYTE_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int ADDR_W = SLOT_W + BYTE_W;
    localparam int STORE_DEPTH = MAX_PATTERNS * (2 ** BYTE_W);

    // Configuration and control registers
    logic [LEN_BITS-1:0]   r_pattern_len;
    logic [BYTE_W-1:0]     r_bcnt;
    logic [CNT_W-1:0]      r_used;
    logic [CNT_W-1:0]      r_slot;
    logic [BYTE_W-1:0]     r_byte;
    logic                  r_o_valid;

    // Memories and their read registers
    logic [BYTE_BITS-1:0]  r_buf_mem [MAX_PATTERN_BYTES];
    logic [BYTE_BITS-1:0]  r_store_mem [STORE_DEPTH];
    logic [COUNT_BITS-1:0] r_cnt_mem [MAX_PATTERNS];
    logic [BYTE_BITS-1:0]  r_buf_rd;
    logic [BYTE_BITS-1:0]  r_store_rd;
    logic [COUNT_BITS-1:0] r_cnt_rd;

    // Staged and output result
    logic                  r_res_new;
    logic                  r_res_full;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic [INDEX_BITS-1:0] r_o_index;
    logic                  r_o_new;
    logic [OCC_BITS-1:0]   r_o_occ;
    logic                  r_o_full;

    logic [LEN_W-1:0]      eff_len;
    logic [BYTE_W-1:0]     wr_idx;
    logic [ADDR_W-1:0]     store_addr;
    logic [SLOT_W-1:0]     slot_idx;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [BYTE_BITS-1:0]  cp_data;
    logic                  append_done;

    // Effective length: zero acts as one, clamp at the entry size
    always_comb begin
        if (r_pattern_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_pattern_len) > MAX_PATTERN_BYTES) begin
            eff_len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = LEN_W'(r_pattern_len);
        end
    end

    assign wr_idx      = (LEN_W'(r_bcnt) >= eff_len) ? '0 : r_bcnt;
    assign slot_idx    = r_slot[SLOT_W-1:0];
    assign store_addr  = {slot_idx, r_byte};
    assign cnt_inc     = (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + COUNT_BITS'(1);
    assign cp_data     = (LEN_W'(r_byte) < eff_len) ? r_buf_rd : '0;
    assign append_done = i_cmd.cp_wr && o_sts.last_pad;

    // Status toward the controller
    assign o_sts.pat_done  = (LEN_W'(wr_idx) + LEN_W'(1)) == eff_len;
    assign o_sts.slot_end  = r_slot == r_used;
    assign o_sts.tbl_full  = r_used == CNT_W'(MAX_PATTERNS);
    assign o_sts.byte_eq   = r_buf_rd == r_store_rd;
    assign o_sts.last_byte = (LEN_W'(r_byte) + LEN_W'(1)) == eff_len;
    assign o_sts.last_pad  = r_byte == BYTE_W'(MAX_PATTERN_BYTES - 1);
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    // Length register, byte collection counter and table fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= LEN_RESET;
            r_bcnt        <= '0;
            r_used        <= '0;
        end else begin
            if (i_cfg_acc) begin
                r_pattern_len <= i_pattern_len;
                r_bcnt        <= '0;
            end else if (i_in_acc) begin
                r_bcnt <= o_sts.pat_done ? '0 : wr_idx + BYTE_W'(1);
            end
            if (append_done) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    // Walk pointers over slots and bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_byte <= '0;
        end else if (i_cmd.start) begin
            r_slot <= '0;
            r_byte <= '0;
        end else if (i_cmd.next_slot) begin
            r_slot <= r_slot + CNT_W'(1);
            r_byte <= '0;
        end else if (i_cmd.clr_byte) begin
            r_byte <= '0;
        end else if (i_cmd.next_byte) begin
            r_byte <= r_byte + BYTE_W'(1);
        end
    end

    // Pattern buffer: written per accepted byte, read during walks
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_buf_mem[wr_idx] <= i_pixel_byte;
        end
        if (i_cmd.rd) begin
            r_buf_rd <= r_buf_mem[r_byte];
        end
    end

    // Pattern store: written and read a byte at a time, zero padded beyond the length
    always_ff @(posedge i_clk) begin
        if (i_cmd.cp_wr) begin
            r_store_mem[store_addr] <= cp_data;
        end
        if (i_cmd.rd) begin
            r_store_rd <= r_store_mem[store_addr];
        end
    end

    // Occurrence counts
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr) begin
            r_cnt_mem[slot_idx] <= cnt_inc;
        end else if (append_done) begin
            r_cnt_mem[slot_idx] <= COUNT_BITS'(1);
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_rd <= r_cnt_mem[slot_idx];
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_wr) begin
            r_res_cnt  <= cnt_inc;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else if (append_done) begin
            r_res_cnt  <= COUNT_BITS'(1);
            r_res_new  <= 1'b1;
            r_res_full <= 1'b0;
        end else if (i_cmd.drop) begin
            r_res_cnt  <= '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_index <= r_res_full ? '0 : INDEX_BITS'(r_slot);
            r_o_new   <= r_res_new;
            r_o_occ   <= OCC_BITS'(r_res_cnt);
            r_o_full  <= r_res_full;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pattern_index = r_o_index;
    assign o_is_new        = r_o_new;
    assign o_occurrences   = r_o_occ;
    assign o_table_full    = r_o_full;

    // Checks
    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(MAX_PATTERNS))
        else $error("fill count beyond table size");

    a_slot_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= r_used)
        else $error("search slot beyond fill count");

    a_bcnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_bcnt) < eff_len)
        else $error("collection counter reached pattern length");

    a_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || !i_stall))
        else $error("result loaded over a pending transaction");

    a_append : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        append_done |=> r_used == $past(r_used) + CNT_W'(1))
        else $error("append did not grow the table");

endmodule

FILE: rtl/upc_ctrl.sv
// ----------------------------------------------------------------------------
// upc_ctrl: controller of the unique pattern counter
// Sequences the table search, the count update, the append copy and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module upc_ctrl
    import upc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_acc,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_idle
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD     = 8'b0000_0010,
        S_CMP    = 8'b0000_0100,
        S_CNT_RD = 8'b0000_1000,
        S_CNT_WR = 8'b0001_0000,
        S_CP_RD  = 8'b0010_0000,
        S_CP_WR  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_idle = r_state == S_IDLE;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc && i_sts.pat_done) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.slot_end) begin
                    if (i_sts.tbl_full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        o_cmd.clr_byte = 1'b1;
                        n_state        = S_CP_RD;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.byte_eq) begin
                    o_cmd.next_slot = 1'b1;
                    n_state         = S_RD;
                end else if (i_sts.last_byte) begin
                    n_state = S_CNT_RD;
                end else begin
                    o_cmd.next_byte = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_OUT;
            end
            S_CP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.cp_wr = 1'b1;
                if (i_sts.last_pad) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.next_byte = 1'b1;
                    n_state         = S_CP_RD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Checks
    a_accept_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_acc |-> r_state == S_IDLE)
        else $error("byte taken outside idle");

    a_search_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_acc && i_sts.pat_done) |=> r_state == S_RD)
        else $error("completed pattern did not start a search");

    a_load_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_state == S_IDLE)
        else $error("result hand-off did not return to idle");

endmodule

FILE: rtl/unique_pattern_counter.sv
// ----------------------------------------------------------------------------
// unique_pattern_counter: histogram of fixed-length byte patterns
// Collects pattern_len bytes into a pattern, looks it up in a table of
// unique patterns, counts hits and appends misses while a slot is free.
// ----------------------------------------------------------------------------
// A byte that does not close a pattern is only written to the pattern buffer.
// A closing byte starts a table walk that compares one byte at a time, each
// as a read state (buffer and store reads are registered) then a compare
// state, and leaves an entry at its first mismatch. A hit then reads and
// writes the count. A miss first sees the end of the table, then copies
// MAX_PATTERN_BYTES zero-padded bytes, a read and a write per byte, or makes
// no copy when the table is full. Every pattern ends by loading the output
// register, which waits while the previous result is still stalled. The
// pattern store's single-byte read port sets the pace of the walk. Input is
// stalled from a closing byte until its result is loaded; a waiting result
// does not stall collection of the next pattern until that pattern completes.
// ----------------------------------------------------------------------------
module unique_pattern_counter
    import upc_pkg::*;
#(
    parameter int MAX_PATTERNS      = MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    parameter int COUNT_BITS        = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_BITS-1:0]  i_pixel_byte,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [INDEX_BITS-1:0] o_pattern_index,
    output logic                  o_is_new,
    output logic [OCC_BITS-1:0]   o_occurrences,
    output logic                  o_table_full,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LEN_BITS-1:0]   i_pattern_len
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    idle;
    logic    in_acc;
    logic    cfg_acc;

    // Transaction qualifiers
    assign o_stall     = !idle;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && idle;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    upc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_acc(in_acc),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    upc_dp #(
        .MAX_PATTERNS     (MAX_PATTERNS),
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .COUNT_BITS       (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_acc       (in_acc),
        .i_pixel_byte   (i_pixel_byte),
        .i_cfg_acc      (cfg_acc),
        .i_pattern_len  (i_pattern_len),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_pattern_index(o_pattern_index),
        .o_is_new       (o_is_new),
        .o_occurrences  (o_occurrences),
        .o_table_full   (o_table_full)
    );

endmodule
